// File: hdl/cstl_pkg.sv
`default_nettype none

package cstl_pkg;

  localparam int KEY_W   = 32;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int FIELD_W = 16;

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [INDEX_W-1:0]        entry_index;
    logic [KEY_W-1:0]          key;
    logic signed [FIELD_W-1:0] player_in;
    logic [FIELD_W-1:0]        value_in;
    logic signed [FIELD_W-1:0] cloak_in;
  } in_t;

  typedef struct packed {
    logic                      found;
    logic signed [FIELD_W-1:0] player_out;
    logic [FIELD_W-1:0]        value_out;
    logic signed [FIELD_W-1:0] cloak_out;
  } out_t;

  // record payload carried by the cache and the table
  typedef struct packed {
    logic signed [FIELD_W-1:0] player;
    logic [FIELD_W-1:0]        value;
    logic signed [FIELD_W-1:0] cloak;
  } rec_t;

  // strobes from the controller to the cache
  typedef struct packed {
    logic cmp;
    logic rd;
    logic fill;
  } cache_ctrl_t;

  // status from the table search unit
  typedef struct packed {
    logic done;
    logic hit;
  } search_stat_t;

endpackage

`default_nettype wire

// File: hdl/cached_sorted_table_lookup.sv
`default_nettype none

// Key-to-record lookup engine. A load transfer (req_type 0) writes one record
// at entry_index into a table that the user must keep sorted by ascending key
// (the block itself does not enforce the order); it gives no result. A lookup
// transfer (req_type 1) first compares the key against all CACHE_ENTRIES cache
// entries at once; the lowest matching entry answers. On a cache miss the
// first entry_count table entries (capped at TABLE_ENTRIES) are binary-searched
// with one table read and one key compare per cycle. A table hit is copied
// into the cache at a round-robin cursor; misses return all-zero fields and
// are not cached. The cache comes out of reset holding all-ones keys and
// records, so a lookup of 0xFFFFFFFF hits until those entries are replaced.
// Table entries have no reset value: searching a range that holds unwritten
// entries gives undefined fields. The input stalls while a lookup is in
// flight; a finished result waits in the output register while the next
// transfer is taken. The user must write entry_count through cfg_we /
// cfg_wdata only while the block is idle; the block itself does not enforce it.

module cached_sorted_table_lookup #(
  parameter int CACHE_ENTRIES = 64,
  parameter int TABLE_ENTRIES = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire cstl_pkg::in_t                in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output cstl_pkg::out_t                    out_data,
  input  wire logic                         cfg_we,
  input  wire logic [cstl_pkg::COUNT_W-1:0] cfg_wdata
);
  import cstl_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CMP  = 6'b000010,
    ST_SEL  = 6'b000100,
    ST_CRD  = 6'b001000,
    ST_SRCH = 6'b010000,
    ST_RESP = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [COUNT_W-1:0] entry_count;
  logic [KEY_W-1:0]  key_q;
  out_t              res, res_next;
  logic              in_xfer, out_xfer, load_we, search_start;
  cache_ctrl_t       cache_ctrl;
  logic              cache_hit;
  rec_t              cache_rec;
  search_stat_t      srch_stat;
  rec_t              srch_rec;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign load_we  = in_xfer && (in_data.req_type == REQ_LOAD);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  // lookup key is held for the whole lookup
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_q <= in_data.key;
    end
  end

  always_comb begin
    state_next   = state;
    res_next     = res;
    cache_ctrl   = '0;
    search_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && (in_data.req_type == REQ_LOOKUP)) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        // register the match vector of all cache entries
        cache_ctrl.cmp = 1'b1;
        state_next     = ST_SEL;
      end
      ST_SEL: begin
        if (cache_hit) begin
          cache_ctrl.rd = 1'b1;
          state_next    = ST_CRD;
        end else begin
          search_start = 1'b1;
          state_next   = ST_SRCH;
        end
      end
      ST_CRD: begin
        res_next   = '{found: 1'b1, player_out: cache_rec.player,
                       value_out: cache_rec.value, cloak_out: cache_rec.cloak};
        state_next = ST_RESP;
      end
      ST_SRCH: begin
        if (srch_stat.done) begin
          if (srch_stat.hit) begin
            // table hit goes into the cache at the fill cursor
            cache_ctrl.fill = 1'b1;
            res_next = '{found: 1'b1, player_out: srch_rec.player,
                         value_out: srch_rec.value, cloak_out: srch_rec.cloak};
          end else begin
            res_next = '0;
          end
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        // wait for room in the output register
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_RESP) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if ((state == ST_RESP) && (!out_valid || !out_stall)) begin
      out_data <= res;
    end
  end

  cstl_cache #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_cache (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (cache_ctrl),
    .key      (key_q),
    .fill_rec (srch_rec),
    .hit      (cache_hit),
    .rec      (cache_rec)
  );

  cstl_search #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .load_we  (load_we),
    .load_idx (in_data.entry_index),
    .load_key (in_data.key),
    .load_rec ('{player: in_data.player_in, value: in_data.value_in,
                 cloak: in_data.cloak_in}),
    .start    (search_start),
    .key      (key_q),
    .count    (entry_count),
    .stat     (srch_stat),
    .rec      (srch_rec)
  );

  a_done_only_in_search: assert property (@(posedge clk) disable iff (rst)
    srch_stat.done |-> (state == ST_SRCH))
    else $error("search finished outside the search state");

  a_fill_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    cache_ctrl.fill |-> (srch_stat.done && srch_stat.hit))
    else $error("cache fill without a table hit");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |->
      ((out_data.player_out == '0) && (out_data.value_out == '0) &&
       (out_data.cloak_out == '0)))
    else $error("miss result carries nonzero fields");

endmodule

`default_nettype wire

// File: hdl/cstl_cache.sv
`default_nettype none

module cstl_cache #(
  parameter int CACHE_ENTRIES = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cstl_pkg::cache_ctrl_t     ctrl,
  input  wire logic [cstl_pkg::KEY_W-1:0] key,
  input  wire cstl_pkg::rec_t            fill_rec,
  output logic                           hit,
  output cstl_pkg::rec_t                 rec
);
  import cstl_pkg::*;

  localparam int CIW = $clog2(CACHE_ENTRIES);

  logic [KEY_W-1:0]         ckey [CACHE_ENTRIES];
  rec_t                     cdata [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] cvalid;
  logic [CIW-1:0]           cursor;
  logic [CACHE_ENTRIES-1:0] match;
  logic [CACHE_ENTRIES-1:0] match_q;
  logic [CACHE_ENTRIES-1:0] first;
  logic [CIW-1:0]           first_idx;
  rec_t                     rdata;
  logic                     rvalid;

  // one comparator per entry
  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      match[i] = (ckey[i] == key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      match_q <= match;
    end
  end

  // lowest matching entry wins
  assign first = match_q & (~match_q + CACHE_ENTRIES'(1));
  assign hit   = |match_q;

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      first_idx = first_idx | (first[i] ? CIW'(i) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        ckey[i] <= '1;
      end
      cvalid <= '0;
      cursor <= '0;
    end else if (ctrl.fill) begin
      ckey[cursor]   <= key;
      cvalid[cursor] <= 1'b1;
      cursor <= (cursor == CIW'(CACHE_ENTRIES - 1)) ? '0 : cursor + CIW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fill) begin
      cdata[cursor] <= fill_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      rdata  <= cdata[first_idx];
      rvalid <= cvalid[first_idx];
    end
  end

  // entries never filled still hold their all-ones reset record
  assign rec = rvalid ? rdata : '1;

  a_rd_needs_match: assert property (@(posedge clk) disable iff (rst)
    ctrl.rd |-> (match_q != '0))
    else $error("cache read issued without a matching entry");

endmodule

`default_nettype wire

// File: hdl/cstl_search.sv
`default_nettype none

module cstl_search #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load_we,
  input  wire logic [cstl_pkg::INDEX_W-1:0]  load_idx,
  input  wire logic [cstl_pkg::KEY_W-1:0]    load_key,
  input  wire cstl_pkg::rec_t                load_rec,
  input  wire logic                          start,
  input  wire logic [cstl_pkg::KEY_W-1:0]    key,
  input  wire logic [cstl_pkg::COUNT_W-1:0]  count,
  output cstl_pkg::search_stat_t             stat,
  output cstl_pkg::rec_t                     rec
);
  import cstl_pkg::*;

  localparam int TW = $clog2(TABLE_ENTRIES);
  localparam int NW = TW + 1;
  localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    rec_t             rec;
  } tword_t;

  typedef enum logic [1:0] {
    SR_IDLE = 2'b01,
    SR_CMP  = 2'b10
  } sr_state_t;

  tword_t    tmem [TABLE_ENTRIES];
  tword_t    rd_word;
  sr_state_t state, state_next;
  logic [NW-1:0] lo, lo_next, hi, hi_next, n_sat;
  logic [TW-1:0] mid, mid_next;
  logic [NW:0]   sum;
  logic          rd_en, key_eq, key_gt;
  logic          done_next, hit_next;

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (load_we && (CW'(load_idx) < CW'(TABLE_ENTRIES))) begin
      tmem[TW'(load_idx)] <= '{key: load_key, rec: load_rec};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= tmem[mid_next];
    end
  end

  // searched length saturates at the table size
  assign n_sat = (CW'(count) > CW'(TABLE_ENTRIES)) ? NW'(TABLE_ENTRIES) : NW'(count);

  // the shared compare unit
  assign key_eq = (rd_word.key == key);
  assign key_gt = (key > rd_word.key);

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    done_next  = 1'b0;
    hit_next   = 1'b0;
    unique case (state)
      SR_IDLE: begin
        if (start) begin
          lo_next = '0;
          hi_next = n_sat;
        end
      end
      SR_CMP: begin
        if (!key_eq) begin
          if (key_gt) begin
            lo_next = {1'b0, mid} + NW'(1);
          end else begin
            hi_next = {1'b0, mid};
          end
        end
      end
      default: begin
        state_next = SR_IDLE;
      end
    endcase
    sum      = {1'b0, lo_next} + {1'b0, hi_next};
    mid_next = sum[TW:1];
    rd_en    = 1'b0;
    unique case (state)
      SR_IDLE: begin
        if (start) begin
          if (n_sat == '0) begin
            done_next = 1'b1;
          end else begin
            rd_en      = 1'b1;
            state_next = SR_CMP;
          end
        end
      end
      SR_CMP: begin
        if (key_eq) begin
          done_next  = 1'b1;
          hit_next   = 1'b1;
          state_next = SR_IDLE;
        end else if (lo_next < hi_next) begin
          rd_en = 1'b1;
        end else begin
          done_next  = 1'b1;
          state_next = SR_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SR_IDLE;
      stat.done <= 1'b0;
      stat.hit  <= 1'b0;
    end else begin
      state     <= state_next;
      stat.done <= done_next;
      stat.hit  <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    if (rd_en) begin
      mid <= mid_next;
    end
    if (hit_next) begin
      rec <= rd_word.rec;
    end
  end

  a_mid_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == SR_CMP) |-> ((lo <= {1'b0, mid}) && ({1'b0, mid} < hi)))
    else $error("search probe outside the live interval");

  a_hit_from_compare: assert property (@(posedge clk) disable iff (rst)
    (stat.done && stat.hit) |-> ($past(state) == SR_CMP))
    else $error("search hit without a table compare");

endmodule

`default_nettype wire

// File: verif/cstl_lookup_checker.sv
`timescale 1ns / 100ps

// watches both channels and the config port, mirrors the cache and table,
// and compares every lookup answer with its prediction in transfer order
module cstl_lookup_checker
  import cstl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_t                in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_t               out_data,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  localparam int CACHE_DEPTH = 64;
  localparam int TABLE_DEPTH = 1024;

  logic [KEY_W-1:0]   cache_key [CACHE_DEPTH];
  rec_t               cache_rec [CACHE_DEPTH];
  logic [5:0]         cursor;
  logic [KEY_W-1:0]   table_key [TABLE_DEPTH];
  rec_t               table_rec [TABLE_DEPTH];
  logic [COUNT_W-1:0] search_count;

  out_t pending_answers[$];
  int   mismatches = 0;

  // cache first, lowest slot wins; then binary search, hits fill the cache
  function automatic out_t predict_answer(input logic [KEY_W-1:0] k);
    out_t r;
    int   i, lo, hi, mid, n;
    r = '0;
    for (i = 0; i < CACHE_DEPTH; i++) begin
      if (cache_key[i] == k) begin
        r.found      = 1'b1;
        r.player_out = cache_rec[i].player;
        r.value_out  = cache_rec[i].value;
        r.cloak_out  = cache_rec[i].cloak;
        return r;
      end
    end
    n  = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(search_count);
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (table_key[mid] == k) begin
        cache_key[cursor] = k;
        cache_rec[cursor] = table_rec[mid];
        cursor            = cursor + 6'd1;
        r.found      = 1'b1;
        r.player_out = table_rec[mid].player;
        r.value_out  = table_rec[mid].value;
        r.cloak_out  = table_rec[mid].cloak;
        return r;
      end
      if (k > table_key[mid]) lo = mid + 1;
      else hi = mid;
    end
    return r;
  endfunction

  function automatic int field_differs(input string what, input logic [FIELD_W-1:0] want_v,
                                       input logic [FIELD_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    out_t want;
    int   i;
    if (rst) begin
      for (i = 0; i < CACHE_DEPTH; i++) begin
        cache_key[i] = '1;
        cache_rec[i] = '1;
      end
      for (i = 0; i < TABLE_DEPTH; i++) begin
        table_key[i] = '0;
        table_rec[i] = '0;
      end
      cursor       = '0;
      search_count = '0;
      pending_answers.delete();
    end else begin
      if (cfg_we) search_count = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (in_data.req_type == REQ_LOAD) begin
          table_key[in_data.entry_index] = in_data.key;
          table_rec[in_data.entry_index] = {in_data.player_in, in_data.value_in,
                                            in_data.cloak_in};
        end else begin
          pending_answers.push_back(predict_answer(in_data.key));
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          mismatches += field_differs("found", FIELD_W'(want.found), FIELD_W'(out_data.found));
          mismatches += field_differs("player_out", want.player_out, out_data.player_out);
          mismatches += field_differs("value_out", want.value_out, out_data.value_out);
          mismatches += field_differs("cloak_out", want.cloak_out, out_data.cloak_out);
        end
      end
    end
    fail_count <= mismatches;
    pending    <= pending_answers.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cstl_pkg::*;

  localparam int TABLE_DEPTH   = 1024;
  // random steps; with the table loads around them the run sends about 1300 items
  localparam int RANDOM_ITEMS  = 200;
  // loads give no result to wait on
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  in_t                in_data;
  logic               out_valid;
  logic               out_stall;
  out_t               out_data;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  int fail_count;
  int pending;

  // idle chances in percent, and a request counter for long receiver hold-offs
  int send_idle_pct;
  int recv_idle_pct;
  int hold_seq;
  int items_done;

  // what the table holds as far as the stimulus knows, used to pick keys
  logic [KEY_W-1:0] shadow_key [TABLE_DEPTH];
  bit               loaded     [TABLE_DEPTH];

  cached_sorted_table_lookup DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cstl_lookup_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stall, or a long hold-off when one is requested
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // offer one transfer after a random gap, hold it until taken
  task automatic send_item(input in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [KEY_W-1:0] k,
                            input logic [FIELD_W-1:0] p, input logic [FIELD_W-1:0] v,
                            input logic [FIELD_W-1:0] c);
    in_t it;
    it.req_type    = REQ_LOAD;
    it.entry_index = idx;
    it.key         = k;
    it.player_in   = p;
    it.value_in    = v;
    it.cloak_in    = c;
    send_item(it);
    shadow_key[idx] = k;
    loaded[idx]     = 1'b1;
  endtask

  // unused fields of a lookup carry random noise
  task automatic lookup_key(input logic [KEY_W-1:0] k);
    in_t it;
    it.req_type    = REQ_LOOKUP;
    it.entry_index = INDEX_W'($urandom);
    it.key         = k;
    it.player_in   = FIELD_W'($urandom);
    it.value_in    = FIELD_W'($urandom);
    it.cloak_in    = FIELD_W'($urandom);
    send_item(it);
  endtask

  // drop valid, wait for every answer, then let any load in flight finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry_count(input logic [COUNT_W-1:0] n);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // searches may only touch written entries, so counts stay within this
  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < TABLE_DEPTH && loaded[n]) n++;
    return n;
  endfunction

  initial begin
    int                 phase, m, n_search, steps, pick, idx, i;
    logic [KEY_W-1:0]   k, gap_max;
    logic [COUNT_W-1:0] cnt;

    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    hold_seq      = 0;
    recv_idle_pct = 0;
    send_idle_pct = 0;
    items_done    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---------------- directed part ----------------
    send_idle_pct = 20;
    recv_idle_pct <= 82;

    // empty search range: all-ones key hits the reset cache, anything else misses
    lookup_key('1);
    lookup_key('0);
    // field extremes and key extremes
    load_entry(10'd0, 32'h0000_0000, 16'h8000, 16'h0000, 16'h7fff);
    load_entry(10'd1, 32'h0000_0005, 16'h7fff, 16'hffff, 16'h8000);
    load_entry(10'd2, 32'hffff_ffff, FIELD_W'($urandom), FIELD_W'($urandom),
               FIELD_W'($urandom));
    load_entry(10'd1023, 32'h8000_0000, FIELD_W'($urandom), FIELD_W'($urandom),
               FIELD_W'($urandom));
    wait_idle();
    write_entry_count(11'd3);
    // table hit fills the cache, the repeat answers from the cache
    lookup_key(32'h0000_0000);
    lookup_key(32'h0000_0000);
    lookup_key(32'h0000_0005);
    lookup_key(32'h0000_0003);
    // several all-ones cache slots match, lowest one answers ahead of the table
    lookup_key(32'hffff_ffff);
    lookup_key(32'hffff_fffe);
    // reload behind a cached key: the cache still answers with old fields
    load_entry(10'd1, 32'h0000_0005, FIELD_W'($urandom), FIELD_W'($urandom),
               FIELD_W'($urandom));
    lookup_key(32'h0000_0005);
    // break the sort order: plain binary search misses the key
    load_entry(10'd0, 32'h0000_0064, FIELD_W'($urandom), FIELD_W'($urandom),
               FIELD_W'($urandom));
    lookup_key(32'h0000_0064);
    lookup_key(32'h0000_0000);
    wait_idle();
    write_entry_count(11'd1);
    lookup_key(32'h0000_0064);

    // ---------------- random part ----------------
    phase = 0;
    while (items_done < RANDOM_ITEMS) begin
      // idling schedule: sender light then heavy, then no idling at all
      if (items_done < RANDOM_ITEMS / 3) begin
        send_idle_pct = 20;
        recv_idle_pct <= 82;
      end else if (items_done < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 82;
        recv_idle_pct <= 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end

      // rebuild a sorted table prefix, mostly small, once the whole table
      if (phase == 1) m = TABLE_DEPTH;
      else if ($urandom_range(0, 5) == 0) m = 1;
      else m = $urandom_range(2, 16);
      // clustered keys make neighbors matter, spread keys reach the high bits
      if ($urandom_range(0, 2) == 0) gap_max = 32'd8;
      else gap_max = 32'hffff_fff0 / m;
      k = $urandom_range(0, gap_max);
      for (i = 0; i < m; i++) begin
        load_entry(INDEX_W'(i), k, FIELD_W'($urandom), FIELD_W'($urandom),
                   FIELD_W'($urandom));
        k = k + $urandom_range(1, gap_max);
      end

      wait_idle();
      // full table searched, then an oversized count over the whole written table
      if (phase == 1) cnt = 11'd1024;
      else if (phase == 6) cnt = 11'd2047;
      else if ($urandom_range(0, 7) == 0) cnt = '0;
      else if ($urandom_range(0, 3) == 0) begin
        if (written_prefix() == TABLE_DEPTH && $urandom_range(0, 1) == 1)
          cnt = COUNT_W'($urandom_range(TABLE_DEPTH + 1, 2047));
        else
          cnt = COUNT_W'($urandom_range(0, written_prefix()));
      end else cnt = COUNT_W'(m);
      write_entry_count(cnt);
      n_search = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);

      steps = $urandom_range(10, 30);
      for (i = 0; i < steps; i++) begin
        // long receiver hold-off while the sender keeps offering
        if ((phase == 2 || phase == 10) && i == 5) hold_seq <= hold_seq + 1;
        // sender pause until every answer is back
        if (i == steps / 2 && phase % 3 == 0) wait_idle();

        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          // stray load, inside the search range or anywhere; may unsort the table
          if (pick < 5 && n_search > 0) idx = $urandom_range(0, n_search - 1);
          else idx = $urandom_range(0, TABLE_DEPTH - 1);
          if (pick % 2 == 0 && loaded[idx]) k = shadow_key[idx];
          else k = $urandom;
          load_entry(INDEX_W'(idx), k, FIELD_W'($urandom), FIELD_W'($urandom),
                     FIELD_W'($urandom));
        end else if (n_search == 0 || pick < 16) begin
          if (pick % 2 == 0) lookup_key($urandom);
          else lookup_key('1);
        end else if (pick < 36) begin
          // just beside a present key, usually a miss
          idx = $urandom_range(0, n_search - 1);
          if (pick % 2 == 0) lookup_key(shadow_key[idx] + 32'd1);
          else lookup_key(shadow_key[idx] - 32'd1);
        end else begin
          lookup_key(shadow_key[$urandom_range(0, n_search - 1)]);
        end
        items_done++;
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
